@@ rtl/core/lmc_pkg.sv @@
// Shared constants, codes and the result record for the LRU miss cache.
// No dependencies; every other file of the block imports this package.
package lmc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PC_W    = 64;
    localparam int CNT_W   = 5;
    localparam int OP_W    = 2;
    localparam int MAX_RES = 16;

    localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_SNAP   = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    typedef struct packed {
        logic             found;
        logic [3:0]       index;
        logic [PC_W-1:0]  listed_pc;
        logic             listed_valid;
        logic [CNT_W-1:0] listed_total;
        logic             last;
    } lmc_res_t;

endpackage

@@ rtl/core/lmc_match.sv @@
// Shared compare unit: one wide equality and one narrow less-than.
// Depends on lmc_pkg; used by the sequencer for the search, aging and list walks over the entries.
module lmc_match (
    input  logic [lmc_pkg::PC_W-1:0]  eq_a,
    input  logic [lmc_pkg::PC_W-1:0]  eq_b,
    input  logic [lmc_pkg::CNT_W-1:0] lt_a,
    input  logic [lmc_pkg::CNT_W-1:0] lt_b,
    output logic                      eq,
    output logic                      lt
);
    import lmc_pkg::*;

    // Compare address and age operands
    assign eq = (eq_a == eq_b);
    assign lt = (lt_a < lt_b);

endmodule

@@ rtl/core/lmc_ctrl.sv @@
// Sequencer and storage: tag, age and snapshot stores walked one entry a cycle.
// Depends on lmc_pkg and lmc_match.
module lmc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lmc_pkg::OP_W-1:0]  op,
    input  logic [lmc_pkg::PC_W-1:0]  pc,
    input  logic [lmc_pkg::CNT_W-1:0] count,
    output logic                      busy,
    output logic                      res_v,
    output lmc_pkg::lmc_res_t         res
);
    import lmc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_AGE   = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_SSRCH = 3'd4;
    localparam logic [2:0] ST_COPY  = 3'd5;
    localparam logic [2:0] ST_LIST  = 3'd6;
    localparam logic [2:0] ST_LEND  = 3'd7;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    logic [2:0]       state_reg,   state_next;
    logic [IDX_W-1:0] idx_reg,     idx_next;
    logic [IDX_W-1:0] sel_reg,     sel_next;
    logic [IDX_W-1:0] sel_age_reg, sel_age_next;
    logic [IDX_W-1:0] lru_reg,     lru_next;
    logic [CNT_W-1:0] n_reg,       n_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic             pend_v_reg,  pend_v_next;
    logic [PC_W-1:0]  pend_pc_reg, pend_pc_next;
    logic [PC_W-1:0]  pc_reg,      pc_next;

    logic [IDX_W-1:0] age_reg [ENTRIES];
    logic [ENTRIES-1:0] tag_vld_reg;
    logic [ENTRIES-1:0] snap_vld_reg;
    logic [PC_W-1:0]  tag_reg  [ENTRIES];
    logic [PC_W-1:0]  snap_reg [ENTRIES];

    logic             age_inc;
    logic             age_clr;
    logic             tag_wr;
    logic             snap_wr;
    logic [PC_W-1:0]  tag_rd;
    logic [PC_W-1:0]  snap_rd;
    logic [IDX_W-1:0] age_rd;
    logic [IDX_W-1:0] age_up;
    logic             idx_last;
    logic [PC_W-1:0]  eq_a;
    logic [CNT_W-1:0] lt_b;
    logic             hit;
    logic             younger;

    // Read the entry under the walk index; invalid entries read as zero
    assign tag_rd   = tag_vld_reg[idx_reg]  ? tag_reg[idx_reg]  : '0;
    assign snap_rd  = snap_vld_reg[idx_reg] ? snap_reg[idx_reg] : '0;
    assign age_rd   = age_reg[idx_reg];
    assign age_up   = age_rd + IDX_W'(1);
    assign idx_last = (idx_reg == IDX_LAST);

    // Steer operands into the shared compare unit
    assign eq_a = (state_reg == ST_SSRCH) ? snap_rd : tag_rd;
    assign lt_b = (state_reg == ST_LIST) ? cnt_reg : {1'b0, sel_age_reg};

    lmc_match u_match (
        .eq_a (eq_a),
        .eq_b (pc_reg),
        .lt_a ({1'b0, age_rd}),
        .lt_b (lt_b),
        .eq   (hit),
        .lt   (younger)
    );

    assign busy = (state_reg != ST_IDLE);

    // Sequence one item over the entries
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sel_next     = sel_reg;
        sel_age_next = sel_age_reg;
        lru_next     = lru_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        pend_v_next  = pend_v_reg;
        pend_pc_next = pend_pc_reg;
        pc_next      = pc_reg;
        age_inc      = 1'b0;
        age_clr      = 1'b0;
        tag_wr       = 1'b0;
        snap_wr      = 1'b0;
        res_v        = 1'b0;
        res          = '0;
        res.last     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pc_next     = pc;
                    cnt_next    = (count > CNT_W'(MAX_RES)) ? CNT_W'(MAX_RES) : count;
                    idx_next    = '0;
                    n_next      = '0;
                    pend_v_next = 1'b0;
                    unique case (op)
                        OP_ACCESS: state_next = ST_SRCH;
                        OP_LOOKUP: state_next = ST_SSRCH;
                        OP_SNAP:   state_next = ST_COPY;
                        OP_LIST:   state_next = ST_LIST;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH:
            begin
                // Take the first matching entry, else the LRU one
                if (hit)
                begin
                    sel_next     = idx_reg;
                    sel_age_next = age_rd;
                    idx_next     = '0;
                    state_next   = ST_AGE;
                end
                else if (idx_last)
                begin
                    sel_next     = lru_reg;
                    sel_age_next = IDX_LAST;
                    idx_next     = '0;
                    state_next   = ST_AGE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_AGE:
            begin
                // Age every entry younger than the chosen one
                if (younger)
                begin
                    age_inc = 1'b1;
                    if (age_up == IDX_LAST)
                        lru_next = idx_reg;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                    state_next = ST_WR;
            end
            ST_WR:
            begin
                age_clr    = 1'b1;
                tag_wr     = 1'b1;
                idx_next   = '0;
                state_next = ST_SSRCH;
            end
            ST_SSRCH:
            begin
                // Report the lowest snapshot position holding the address
                if (hit)
                begin
                    res_v      = 1'b1;
                    res.found  = 1'b1;
                    res.index  = 4'(idx_reg);
                    state_next = ST_IDLE;
                end
                else if (idx_last)
                begin
                    res_v      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_COPY:
            begin
                snap_wr  = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    res_v      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                // Hold one qualifying address back so the final one can carry last
                if (younger)
                begin
                    if (pend_v_reg)
                    begin
                        res_v            = 1'b1;
                        res.listed_pc    = pend_pc_reg;
                        res.listed_valid = 1'b1;
                        res.listed_total = n_reg;
                        res.last         = 1'b0;
                    end
                    pend_v_next  = 1'b1;
                    pend_pc_next = tag_rd;
                    n_next       = n_reg + CNT_W'(1);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_last || (younger && (n_reg + CNT_W'(1) == cnt_reg)))
                    state_next = ST_LEND;
            end
            ST_LEND:
            begin
                res_v = 1'b1;
                if (pend_v_reg)
                begin
                    res.listed_pc    = pend_pc_reg;
                    res.listed_valid = 1'b1;
                    res.listed_total = n_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state, ages and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            sel_reg      <= '0;
            sel_age_reg  <= '0;
            lru_reg      <= IDX_LAST;
            n_reg        <= '0;
            cnt_reg      <= '0;
            pend_v_reg   <= 1'b0;
            tag_vld_reg  <= '0;
            snap_vld_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= IDX_W'(i);
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            sel_reg     <= sel_next;
            sel_age_reg <= sel_age_next;
            lru_reg     <= lru_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            pend_v_reg  <= pend_v_next;
            if (age_inc)
                age_reg[idx_reg] <= age_up;
            if (age_clr)
                age_reg[sel_reg] <= '0;
            if (tag_wr)
                tag_vld_reg[sel_reg] <= 1'b1;
            if (snap_wr)
                snap_vld_reg[idx_reg] <= tag_vld_reg[idx_reg];
        end
    end

    // Hold payload registers and stores
    always_ff @(posedge clk)
    begin
        pc_reg      <= pc_next;
        pend_pc_reg <= pend_pc_next;
        if (tag_wr)
            tag_reg[sel_reg] <= pc_reg;
        if (snap_wr)
            snap_reg[idx_reg] <= tag_reg[idx_reg];
    end

    a_lru_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (age_reg[lru_reg] == IDX_LAST))
        else $error("lru pointer does not name the oldest entry");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_v |-> busy)
        else $error("result raised while idle");

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (n_reg < cnt_reg || cnt_reg == '0))
        else $error("list emitted past its limit");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v && res.last) |=> (state_reg == ST_IDLE))
        else $error("item kept running after its final result");

endmodule

@@ rtl/core/lru_miss_cache_with_snapshot.sv @@
// Top level of the LRU miss cache with snapshot: command port and result register.
// Depends on lmc_pkg and lmc_ctrl.
//
//   channel   handshake             payload
//   command   start, busy           op, pc, count
//   result    done (one cycle)      found, index, listed_pc, listed_valid,
//                                   listed_total, last
//
// An item is taken when start is high and busy is low; busy stays high until
// its final result leaves the sequencer. Searches, aging and lists walk the 16
// entries one per cycle through a single shared compare unit, and the snapshot
// copy walks them likewise; access runs a search, an aging pass, one write and a
// snapshot search. Results appear in the cycle after the sequencer forms them.
// Reset is asynchronous and needs no clearing pass. The receiver cannot stall.
module lru_miss_cache_with_snapshot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [lmc_pkg::OP_W-1:0]  op,
    input  logic [lmc_pkg::PC_W-1:0]  pc,
    input  logic [lmc_pkg::CNT_W-1:0] count,
    output logic                      done,
    output logic                      found,
    output logic [3:0]                index,
    output logic [lmc_pkg::PC_W-1:0]  listed_pc,
    output logic                      listed_valid,
    output logic [lmc_pkg::CNT_W-1:0] listed_total,
    output logic                      last
);
    import lmc_pkg::*;

    logic     res_v;
    lmc_res_t res;
    logic     done_reg;
    lmc_res_t res_reg;

    lmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .pc    (pc),
        .count (count),
        .busy  (busy),
        .res_v (res_v),
        .res   (res)
    );

    // Register the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= res_v;
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res;
    end

    assign done         = done_reg;
    assign found        = res_reg.found;
    assign index        = res_reg.index;
    assign listed_pc    = res_reg.listed_pc;
    assign listed_valid = res_reg.listed_valid;
    assign listed_total = res_reg.listed_total;
    assign last         = res_reg.last;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for lru_miss_cache_with_snapshot: directed and random items
// through the start/busy port, every result checked against an in-bench cache predictor.
// Depends on lmc_pkg and the block's RTL.
module testbench;
    import lmc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_END   = 80;
    localparam int SETTLE_PAUSE = 4;
    localparam int RANDOM_ITEMS = 450;
    localparam int POOL_SIZE    = 24;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    op;
    logic [PC_W-1:0]    pc;
    logic [CNT_W-1:0]   count;
    logic               done;
    logic               found;
    logic [3:0]         index;
    logic [PC_W-1:0]    listed_pc;
    logic               listed_valid;
    logic [CNT_W-1:0]   listed_total;
    logic               last;

    // Predicted cache contents
    logic [PC_W-1:0]    tag_mirror [ENTRIES];
    logic [IDX_W-1:0]   age_mirror [ENTRIES];
    logic [PC_W-1:0]    snap_mirror [ENTRIES];
    logic [IDX_W-1:0]   lru_mirror;

    lmc_res_t           pending_results [$];
    lmc_res_t           oldest_result;
    int unsigned        error_count;
    int unsigned        results_checked;
    int unsigned        cycle_count;
    int unsigned        op_count [4];

    lru_miss_cache_with_snapshot i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .pc           (pc),
        .count        (count),
        .done         (done),
        .found        (found),
        .index        (index),
        .listed_pc    (listed_pc),
        .listed_valid (listed_valid),
        .listed_total (listed_total),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD/2) clk = ~clk;
    end

    // Bring the predicted cache to its post-reset contents
    task automatic cache_reset();
        for (int i = 0; i < ENTRIES; i++)
        begin
            tag_mirror[i]  = '0;
            age_mirror[i]  = IDX_W'(i);
            snap_mirror[i] = '0;
        end
        lru_mirror = IDX_W'(ENTRIES - 1);
        pending_results.delete();
    endtask

    // Find the lowest snapshot position that holds the address
    function automatic lmc_res_t snap_search(logic [PC_W-1:0] addr);
        lmc_res_t r;
        r      = '0;
        r.last = 1'b1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (snap_mirror[i] == addr)
            begin
                r.found = 1'b1;
                r.index = 4'(i);
                return r;
            end
        end
        return r;
    endfunction

    // Touch an address: pick hit entry or LRU victim, age younger entries, make it youngest
    task automatic cache_touch(logic [PC_W-1:0] addr);
        int unsigned sel;
        int unsigned sel_age;
        sel     = lru_mirror;
        sel_age = ENTRIES - 1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tag_mirror[i] == addr)
            begin
                sel     = i;
                sel_age = age_mirror[i];
                break;
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (age_mirror[i] < sel_age)
            begin
                age_mirror[i] = age_mirror[i] + 1'b1;
                if (age_mirror[i] == IDX_W'(ENTRIES - 1))
                    lru_mirror = IDX_W'(i);
            end
        end
        age_mirror[sel] = '0;
        tag_mirror[sel] = addr;
    endtask

    // Work out the results of one accepted item and queue them
    task automatic predict_item(logic [OP_W-1:0] o, logic [PC_W-1:0] addr,
                                logic [CNT_W-1:0] cnt);
        lmc_res_t    r;
        lmc_res_t    held;
        int unsigned limit;
        int unsigned emitted;
        r      = '0;
        r.last = 1'b1;
        case (o)
            OP_ACCESS:
            begin
                cache_touch(addr);
                pending_results.push_back(snap_search(addr));
            end
            OP_LOOKUP:
            begin
                pending_results.push_back(snap_search(addr));
            end
            OP_SNAP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    snap_mirror[i] = tag_mirror[i];
                pending_results.push_back(r);
            end
            default:
            begin
                limit   = (cnt > MAX_RES) ? MAX_RES : cnt;
                emitted = 0;
                held    = '0;
                // Hold back each entry until the next one shows up so the final one gets last
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (emitted >= limit)
                        break;
                    if (age_mirror[i] < limit)
                    begin
                        if (emitted != 0)
                            pending_results.push_back(held);
                        held              = '0;
                        held.listed_pc    = tag_mirror[i];
                        held.listed_valid = 1'b1;
                        held.listed_total = CNT_W'(emitted + 1);
                        emitted++;
                    end
                end
                if (emitted == 0)
                    pending_results.push_back(r);
                else
                begin
                    held.last = 1'b1;
                    pending_results.push_back(held);
                end
            end
        endcase
    endtask

    // Present one item and hold it until the block takes it; start stays high on return
    task automatic send_item(logic [OP_W-1:0] o, logic [PC_W-1:0] addr,
                             logic [CNT_W-1:0] cnt);
        start <= 1'b1;
        op    <= o;
        pc    <= addr;
        count <= cnt;
        do
            @(posedge clk);
        while (busy);
        predict_item(o, addr, cnt);
        op_count[o]++;
    endtask

    // Drop start for a gap between bursts
    task automatic hold_off(int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending until every queued result has come back
    task automatic wait_drained(int unsigned settle);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Look up in the all-zero snapshot and list the table straight after reset
    task automatic test_reset_state();
        send_item(OP_LOOKUP, 64'h0, 5'd0);
        send_item(OP_LOOKUP, '1, 5'd31);
        send_item(OP_LIST, 64'h0, 5'd16);
        send_item(OP_LIST, '1, 5'd0);
    endtask

    // Hit among the reset zeros, miss into the LRU entry, then hit a filled entry
    task automatic test_access_hit_miss();
        send_item(OP_ACCESS, 64'h0, 5'd0);
        send_item(OP_ACCESS, '1, 5'd31);
        send_item(OP_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA, 5'd10);
        send_item(OP_ACCESS, 64'h5555_5555_5555_5555, 5'd21);
        send_item(OP_ACCESS, '1, 5'd0);
    endtask

    // Refresh the snapshot, then look up present, absent and zero addresses
    task automatic test_snapshot_lookup();
        send_item(OP_SNAP, 64'hDEAD_BEEF_0123_4567, 5'd31);
        send_item(OP_LOOKUP, '1, 5'd0);
        send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 5'd5);
        send_item(OP_LOOKUP, 64'h0000_1234_0000_5678, 5'd16);
        send_item(OP_LOOKUP, 64'h0, 5'd0);
    endtask

    // List with small counts, the full table and counts that saturate
    task automatic test_list_bounds();
        send_item(OP_LIST, 64'h0, 5'd1);
        send_item(OP_LIST, '1, 5'd3);
        send_item(OP_LIST, 64'h0, 5'd31);
        send_item(OP_LIST, '1, 5'd17);
        send_item(OP_LIST, 64'h0, 5'd16);
    endtask

    // Mostly accesses and lookups over a small address pool, sent in bursts
    task automatic test_random_traffic();
        logic [PC_W-1:0]  addr_pool [POOL_SIZE];
        logic [PC_W-1:0]  addr;
        logic [OP_W-1:0]  o;
        logic [CNT_W-1:0] cnt;
        int unsigned      burst_left;
        int unsigned      pick;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = {$urandom, $urandom};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        burst_left   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained(SETTLE_PAUSE);
            // Start a new burst, usually after a gap
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                o = OP_ACCESS;
            else if (pick < 70)
                o = OP_LOOKUP;
            else if (pick < 78)
                o = OP_SNAP;
            else
                o = OP_LIST;
            if ($urandom_range(0, 4) == 0)
                addr = {$urandom, $urandom};
            else
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 7) == 0)
                cnt = CNT_W'($urandom_range(17, 31));
            else
                cnt = CNT_W'($urandom_range(0, 16));
            send_item(o, addr, cnt);
        end
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: listed_pc 0x%0h last %0b",
                       listed_pc, last);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                compare_field("found", 64'(oldest_result.found), 64'(found));
                compare_field("index", 64'(oldest_result.index), 64'(index));
                compare_field("listed_pc", oldest_result.listed_pc, listed_pc);
                compare_field("listed_valid", 64'(oldest_result.listed_valid),
                              64'(listed_valid));
                compare_field("listed_total", 64'(oldest_result.listed_total),
                              64'(listed_total));
                compare_field("last", 64'(oldest_result.last), 64'(last));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        op              <= OP_ACCESS;
        pc              <= '0;
        count           <= '0;
        error_count     = 0;
        results_checked = 0;
        cycle_count     = 0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        cache_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        wait_drained(SETTLE_PAUSE);
        test_access_hit_miss();
        test_snapshot_lookup();
        wait_drained(SETTLE_PAUSE);
        test_list_bounds();
        test_random_traffic();
        wait_drained(SETTLE_END);

        $display("Ran %0d accesses, %0d lookups, %0d snapshots and %0d lists;",
                 op_count[OP_ACCESS], op_count[OP_LOOKUP], op_count[OP_SNAP],
                 op_count[OP_LIST]);
        $display("%0d results compared, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
